// ===== sv/kdi_pkg.sv =====
// kdi_pkg: shared types, constants and helpers of the k-mer direct index
// depends on nothing; imported by kdi_decode, kmer_direct_index_unit and kdi_checker

package kdi_pkg;

	// field widths fixed by the item formats
	localparam int STR_W   = 16;
	localparam int POS_W   = 20;
	localparam int SYM_W   = 8;
	localparam int STAT_W  = 3;
	localparam int TOT_W   = 32;
	localparam int K_W     = 4;

	// parameter defaults
	localparam int MAX_K_DEF       = 8;
	localparam int ENTRY_DEPTH_DEF = 65536;
	localparam int MAX_HITS_DEF    = 64;

	localparam logic [K_W-1:0]   KLEN_RESET = 4'd8;
	localparam logic [POS_W-1:0] POS_MAX    = 20'hFFFFF;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SYM   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_POOL_FULL = 3'd2;
	localparam logic [STAT_W-1:0] STAT_TRUNC     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_POS_OVF   = 3'd4;

	// what the item needs after decode
	localparam logic [1:0] ACT_STATUS = 2'd0;
	localparam logic [1:0] ACT_PUSH   = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;

	localparam logic MODE_BUILD = 1'b0;

	typedef struct packed {
		logic             mode;
		logic             first_char;
		logic [SYM_W-1:0] symbol;
		logic [STR_W-1:0] string_number;
	} item_t;

	typedef struct packed {
		logic [STR_W-1:0]  hit_string;
		logic [POS_W-1:0]  hit_position;
		logic              hit_valid;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [TOT_W-1:0]  total_hits;
	} result_t;

	typedef struct packed {
		logic [1:0]        act;
		logic [STAT_W-1:0] status;
		logic              err;
	} dec_t;

	// 2-bit base code, valid flag on top
	function automatic logic [2:0] base_code(input logic [SYM_W-1:0] s);
		logic [2:0] r;
		case (s)
			8'h41: r = 3'b100;
			8'h43: r = 3'b101;
			8'h47: r = 3'b110;
			8'h54: r = 3'b111;
			default: r = 3'b000;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/kdi_ram.sv =====
// kdi_ram: generic simple dual-port ram, one write and one registered read port
// no package dependencies

module kdi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/kdi_decode.sv =====
// kdi_decode: per-character decode, rolling code and position update
// depends on kdi_pkg

module kdi_decode import kdi_pkg::*; #(
	parameter int MAX_K       = MAX_K_DEF,
	parameter int ENTRY_DEPTH = ENTRY_DEPTH_DEF
) (
	input  item_t                             item,
	input  logic [K_W-1:0]                    kmer_length,
	input  logic [2*MAX_K-1:0]                code,
	input  logic [POS_W-1:0]                  count,
	input  logic                              err,
	input  logic [$clog2(ENTRY_DEPTH+1)-1:0]  fill,
	output dec_t                              dec,
	output logic [2*MAX_K-1:0]                code_nx,
	output logic [POS_W-1:0]                  count_nx,
	output logic [POS_W-1:0]                  pos
);

	localparam int CODE_W = 2 * MAX_K;
	localparam int FILL_W = $clog2(ENTRY_DEPTH + 1);

	logic [K_W-1:0]    k_eff;
	logic [CODE_W-1:0] code_base;
	logic [CODE_W-1:0] mask;
	logic [POS_W-1:0]  cnt_base;
	logic              err_base;
	logic [2:0]        bc;

	always_comb begin
		if (kmer_length == '0) begin
			k_eff = K_W'(1);
		end else if (kmer_length > K_W'(MAX_K)) begin
			k_eff = K_W'(MAX_K);
		end else begin
			k_eff = kmer_length;
		end
	end

	assign code_base = item.first_char ? '0 : code;
	assign cnt_base  = item.first_char ? '0 : count;
	assign err_base  = item.first_char ? 1'b0 : err;
	assign bc        = base_code(item.symbol);
	assign mask      = ~({CODE_W{1'b1}} << {k_eff, 1'b0});
	assign pos       = count_nx - POS_W'(k_eff);

	always_comb begin
		code_nx    = code_base;
		count_nx   = cnt_base;
		dec.act    = ACT_STATUS;
		dec.status = STAT_OK;
		dec.err    = err_base;
		if (!bc[2]) begin
			dec.err    = 1'b1;
			dec.status = STAT_BAD_SYM;
		end else if (err_base) begin
			dec.status = STAT_BAD_SYM;
		end else if (cnt_base == POS_MAX) begin
			dec.status = STAT_POS_OVF;
		end else begin
			code_nx  = ((code_base << 2) | CODE_W'(bc[1:0])) & mask;
			count_nx = cnt_base + POS_W'(1);
			if (item.mode == MODE_BUILD) begin
				if (count_nx >= POS_W'(k_eff)) begin
					if (fill == FILL_W'(ENTRY_DEPTH)) begin
						dec.status = STAT_POOL_FULL;
					end else begin
						dec.act = ACT_PUSH;
					end
				end
			end else if (count_nx == POS_W'(k_eff)) begin
				dec.act = ACT_LOOKUP;
			end
		end
	end

endmodule

// ===== sv/kmer_direct_index_unit.sv =====
// kmer_direct_index_unit: top level of the direct-address k-mer index
// depends on kdi_pkg, kdi_decode and kdi_ram
//
// The block takes one DNA character per item transfer and builds or queries a
// direct-address k-mer index held in two synchronous rams: a head table with
// one entry per 2k-bit code (valid bit plus newest entry index) and an entry
// pool of (string, position, link) records. After reset the head table is
// swept clear one entry per cycle, all 2^(2*MAX_K) entries (65536 at the
// default), during which item_ready stays low; cfg writes are taken at any
// time. An item is handled in the accept cycle, which decodes the character
// and issues the head read, and then in the S_HEAD state, which waits for a
// free result slot and writes back the head and the new entry (build) or
// starts the chain walk (query). A query that hits then walks the chain at
// one entry per cycle, set by the entry ram read latency, emitting one hit
// result per cycle while result_ready stays high. A result register sits
// between the core and the result port, so the next item can be accepted
// while a result is still waiting to be taken. The next item is accepted
// only after the previous one has finished its ram writes, so no head read
// can overlap a pending write to the same entry.

module kmer_direct_index_unit import kdi_pkg::*; #(
	parameter int MAX_K              = MAX_K_DEF,
	parameter int ENTRY_DEPTH        = ENTRY_DEPTH_DEF,
	parameter int MAX_HITS_PER_QUERY = MAX_HITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	// item channel
	input  logic           item_valid,
	output logic           item_ready,
	input  item_t          item,
	// result channel
	output logic           result_valid,
	input  logic           result_ready,
	output result_t        result,
	// kmer_length register write
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [K_W-1:0] cfg_data
);

	localparam int CODE_W     = 2 * MAX_K;
	localparam int HEAD_DEPTH = 1 << CODE_W;
	localparam int IDX_W      = $clog2(ENTRY_DEPTH);
	localparam int FILL_W     = $clog2(ENTRY_DEPTH + 1);
	localparam int HEAD_W     = IDX_W + 1;
	localparam int ENT_W      = STR_W + POS_W + 1 + IDX_W;
	localparam int HIT_W      = $clog2(MAX_HITS_PER_QUERY + 1);

	// sequencer states
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_HEAD  = 2'd2;
	localparam logic [1:0] S_WALK  = 2'd3;

	logic [1:0]        state_q;
	logic [CODE_W-1:0] clr_q;

	// architectural state
	logic [K_W-1:0]    klen_q;
	logic [CODE_W-1:0] code_q;
	logic [POS_W-1:0]  count_q;
	logic              err_q;
	logic [FILL_W-1:0] fill_q;
	logic [TOT_W-1:0]  total_q;
	logic [HIT_W-1:0]  nhit_q;

	// decoded item held for the write-back / walk cycle
	logic [1:0]        act_s1;
	logic [STAT_W-1:0] stat_s1;
	logic [STR_W-1:0]  str_s1;
	logic [POS_W-1:0]  pos_s1;

	// result register
	logic              res_valid_q;
	result_t           res_q;

	// decode outputs
	dec_t              dec;
	logic [CODE_W-1:0] code_nx;
	logic [POS_W-1:0]  count_nx;
	logic [POS_W-1:0]  pos_nx;

	// ram ports
	logic              head_we;
	logic [CODE_W-1:0] head_waddr;
	logic [HEAD_W-1:0] head_wdata;
	logic              head_re;
	logic [HEAD_W-1:0] head_rd;
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic              ent_re;
	logic [IDX_W-1:0]  ent_raddr;
	logic [ENT_W-1:0]  ent_rd;

	// unpacked ram read data
	logic              head_ok;
	logic [IDX_W-1:0]  head_idx;
	logic [STR_W-1:0]  ent_str;
	logic [POS_W-1:0]  ent_pos;
	logic              ent_link_ok;
	logic [IDX_W-1:0]  ent_link;

	logic              accept;
	logic              out_free;
	logic              emit;
	result_t           emit_data;
	logic [1:0]        state_nx;
	logic              walk_more;
	logic [TOT_W-1:0]  total_inc;

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;
	// result slot is free or drains this cycle
	assign out_free     = !res_valid_q || result_ready;

	assign head_ok     = head_rd[IDX_W];
	assign head_idx    = head_rd[IDX_W-1:0];
	assign ent_str     = ent_rd[ENT_W-1 -: STR_W];
	assign ent_pos     = ent_rd[IDX_W+POS_W -: POS_W];
	assign ent_link_ok = ent_rd[IDX_W];
	assign ent_link    = ent_rd[IDX_W-1:0];

	// saturating running hit total
	assign total_inc = (total_q == '1) ? total_q : total_q + TOT_W'(1);
	// chain continues and the per-query limit is not reached yet
	assign walk_more = ent_link_ok && (nhit_q != HIT_W'(MAX_HITS_PER_QUERY - 1));

	kdi_decode #(
		.MAX_K      (MAX_K),
		.ENTRY_DEPTH(ENTRY_DEPTH)
	) u_decode (
		.item       (item),
		.kmer_length(klen_q),
		.code       (code_q),
		.count      (count_q),
		.err        (err_q),
		.fill       (fill_q),
		.dec        (dec),
		.code_nx    (code_nx),
		.count_nx   (count_nx),
		.pos        (pos_nx)
	);

	kdi_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(HEAD_DEPTH)
	) u_head_ram (
		.clk  (clk),
		.we   (head_we),
		.waddr(head_waddr),
		.wdata(head_wdata),
		.re   (head_re),
		.raddr(code_nx),
		.rdata(head_rd)
	);

	kdi_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRY_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_waddr),
		.wdata(ent_wdata),
		.re   (ent_re),
		.raddr(ent_raddr),
		.rdata(ent_rd)
	);

	// sequencer: ram control and result formation
	always_comb begin
		state_nx   = state_q;
		head_we    = 1'b0;
		head_waddr = code_q;
		head_wdata = {1'b1, fill_q[IDX_W-1:0]};
		// head read is issued at the accept edge for the new code
		head_re    = accept;
		ent_we     = 1'b0;
		ent_waddr  = fill_q[IDX_W-1:0];
		ent_wdata  = {str_s1, pos_s1, head_rd};
		ent_re     = 1'b0;
		ent_raddr  = head_idx;
		emit       = 1'b0;
		emit_data  = '{hit_string: '0, hit_position: '0, hit_valid: 1'b0,
			last: 1'b1, status: stat_s1, total_hits: total_q};
		case (state_q)
			S_CLEAR: begin
				// sweep the head table empty after reset
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = '0;
				if (clr_q == '1) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_nx = S_HEAD;
				end
			end
			S_HEAD: begin
				if (out_free) begin
					case (act_s1)
						ACT_PUSH: begin
							// new entry links to the old head, head points at it
							ent_we   = 1'b1;
							head_we  = 1'b1;
							emit     = 1'b1;
							state_nx = S_IDLE;
						end
						ACT_LOOKUP: begin
							if (head_ok) begin
								ent_re   = 1'b1;
								state_nx = S_WALK;
							end else begin
								emit     = 1'b1;
								state_nx = S_IDLE;
							end
						end
						default: begin
							emit     = 1'b1;
							state_nx = S_IDLE;
						end
					endcase
				end
			end
			S_WALK: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_data = '{hit_string: ent_str, hit_position: ent_pos,
						hit_valid: 1'b1, last: !walk_more,
						status: (!walk_more && ent_link_ok) ? STAT_TRUNC : STAT_OK,
						total_hits: total_inc};
					if (walk_more) begin
						ent_re    = 1'b1;
						ent_raddr = ent_link;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			klen_q      <= KLEN_RESET;
			code_q      <= '0;
			count_q     <= '0;
			err_q       <= 1'b0;
			fill_q      <= '0;
			total_q     <= '0;
			nhit_q      <= '0;
			act_s1      <= ACT_STATUS;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CODE_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				klen_q <= cfg_data;
			end
			if (accept) begin
				code_q  <= code_nx;
				count_q <= count_nx;
				err_q   <= dec.err;
				act_s1  <= dec.act;
				nhit_q  <= '0;
			end
			if (ent_we) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (emit && state_q == S_WALK) begin
				total_q <= total_inc;
				nhit_q  <= nhit_q + HIT_W'(1);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= dec.status;
			str_s1  <= item.string_number;
			pos_s1  <= pos_nx;
		end
		if (emit) begin
			res_q <= emit_data;
		end
	end

endmodule

// ===== sv/kdi_checker.sv =====
// kdi_checker: port-level assertions for the k-mer direct index
// depends on kdi_pkg; bound to kmer_direct_index_unit at the end of this file

module kdi_checker import kdi_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_ready,
	input item_t   item,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	// a waiting item holds its payload until the transfer
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("item changed while waiting");

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// one item at a time: ready drops right after an item transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted twice in a row");

	// a status-only result is always the final one and carries no hit
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit_valid |->
			result.last && result.hit_string == '0 && result.hit_position == '0)
		else $error("malformed status-only result");

	// truncation is flagged only on the final hit of a query
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == STAT_TRUNC |->
			result.hit_valid && result.last)
		else $error("truncation status on a non-final hit");

endmodule

bind kmer_direct_index_unit kdi_checker u_kdi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
